>>> rtl/zbcw_pkg.sv
// ----------------------------------------------------------------------------
// zbcw_pkg
// Types, constants and the brightness ramp table shared by the character
// cell writer and its sub-blocks.
// ----------------------------------------------------------------------------
package zbcw_pkg;

   localparam int unsigned SCREEN_WIDTH_DEF  = 640;
   localparam int unsigned SCREEN_HEIGHT_DEF = 128;
   localparam int unsigned RAMP_LEN_DEF      = 92;

   localparam int unsigned COORD_W     = 12;
   localparam int unsigned CELL_W      = 2 * COORD_W;
   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned DEPTH_W     = 16;
   localparam int unsigned FIELD_W     = 16;
   localparam int unsigned ROM_SIZE    = 92;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 7'h20;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] RAMP_ROM [ROM_SIZE] = '{
      7'h20, 7'h60, 7'h2E, 7'h2D, 7'h27, 7'h3A, 7'h5F, 7'h2C, 7'h5E, 7'h3D,
      7'h3B, 7'h3E, 7'h3C, 7'h2B, 7'h21, 7'h72, 7'h63, 7'h2A, 7'h2F, 7'h7A,
      7'h3F, 7'h73, 7'h4C, 7'h54, 7'h76, 7'h29, 7'h4A, 7'h37, 7'h28, 7'h7C,
      7'h46, 7'h69, 7'h7B, 7'h43, 7'h7D, 7'h66, 7'h49, 7'h33, 7'h31, 7'h74,
      7'h6C, 7'h75, 7'h5B, 7'h6E, 7'h65, 7'h6F, 7'h5A, 7'h35, 7'h59, 7'h78,
      7'h6A, 7'h79, 7'h61, 7'h5D, 7'h32, 7'h45, 7'h53, 7'h77, 7'h71, 7'h6B,
      7'h50, 7'h36, 7'h68, 7'h39, 7'h64, 7'h34, 7'h56, 7'h70, 7'h4F, 7'h47,
      7'h62, 7'h55, 7'h41, 7'h4B, 7'h58, 7'h48, 7'h6D, 7'h38, 7'h52, 7'h44,
      7'h23, 7'h24, 7'h42, 7'h67, 7'h30, 7'h4D, 7'h4E, 7'h57, 7'h51, 7'h25,
      7'h26, 7'h40
   };

   typedef struct packed {
      logic [1:0]                op;
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic signed [FIELD_W-1:0] brightness;
      logic signed [FIELD_W-1:0] depth;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]         char_code;
      logic signed [DEPTH_W-1:0] depth_out;
      logic                      drawn;
      logic                      in_bounds;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      in_bounds;
      logic [CELL_W-1:0]         cell_addr;
      logic signed [DEPTH_W-1:0] depth;
      logic [CHAR_W-1:0]         char_code;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_CLEAR
   } back_state_type;

   function automatic logic [CHAR_W-1:0] ramp_char(input logic [7:0] level,
                                                   input int unsigned ramp_len);
      logic [15:0] prod;
      logic [15:0] sum;
      logic [7:0]  idx;
      prod = 16'(level) * 16'(ramp_len - 1);
      sum  = prod + {8'd0, prod[15:8]} + 16'd1;
      idx  = sum[15:8];
      if (idx > 8'(ROM_SIZE - 1)) begin
         idx = 8'(ROM_SIZE - 1);
      end
      return RAMP_ROM[idx[6:0]];
   endfunction

endpackage

>>> rtl/zbcw_ram.sv
// ----------------------------------------------------------------------------
// zbcw_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module zbcw_ram #(
   parameter int unsigned DATA_WIDTH = 8,
   parameter int unsigned DEPTH      = 16,
   localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/zbcw_front.sv
// ----------------------------------------------------------------------------
// zbcw_front
// Request intake: bounds check, cell address, brightness clamp and ramp
// lookup, producing one command for the queue.
// ----------------------------------------------------------------------------
module zbcw_front #(
   parameter int unsigned SCREEN_WIDTH  = zbcw_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT = zbcw_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned RAMP_LEN      = zbcw_pkg::RAMP_LEN_DEF
) (
   input  logic              start,
   input  zbcw_pkg::req_type req,
   input  logic              queue_full,
   input  logic              init_busy,
   output logic              busy,
   output logic              push,
   output zbcw_pkg::cmd_type entry
);

   logic       x_ok;
   logic       y_ok;
   logic       on_screen;
   logic [7:0] level;

   assign busy = queue_full | init_busy;
   assign push = start & ~busy;

   assign x_ok = ~req.x[15] &&
                 ({1'b0, req.x[14:0]} < 16'(SCREEN_WIDTH));
   assign y_ok = ~req.y[15] &&
                 ({1'b0, req.y[14:0]} < 16'(SCREEN_HEIGHT));
   assign on_screen = x_ok & y_ok;

   always_comb begin
      if (req.brightness[15]) begin
         level = 8'd0;
      end else if (req.brightness[14:8] != 7'd0) begin
         level = 8'd255;
      end else begin
         level = req.brightness[7:0];
      end
   end

   always_comb begin
      entry.cell_addr = zbcw_pkg::CELL_W'(req.y[zbcw_pkg::COORD_W-1:0]) *
                        zbcw_pkg::CELL_W'(SCREEN_WIDTH) +
                        zbcw_pkg::CELL_W'(req.x[zbcw_pkg::COORD_W-1:0]);
      entry.depth     = req.depth;
      entry.char_code = zbcw_pkg::ramp_char(level, RAMP_LEN);
      entry.in_bounds = 1'b0;
      if (req.op == zbcw_pkg::OP_WRITE) begin
         entry.kind      = zbcw_pkg::CMD_WRITE;
         entry.in_bounds = on_screen;
      end else if (req.op == zbcw_pkg::OP_READ) begin
         entry.kind      = zbcw_pkg::CMD_READ;
         entry.in_bounds = on_screen;
      end else if (req.op == zbcw_pkg::OP_CLEAR) begin
         entry.kind = zbcw_pkg::CMD_CLEAR;
      end else begin
         entry.kind = zbcw_pkg::CMD_NOP;
      end
   end

endmodule

>>> rtl/zbcw_queue.sv
// ----------------------------------------------------------------------------
// zbcw_queue
// Two-entry command queue between the intake and the cell engine.
// ----------------------------------------------------------------------------
module zbcw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  zbcw_pkg::cmd_type push_entry,
   input  logic              pop,
   output zbcw_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   localparam int unsigned PtrW = $clog2(zbcw_pkg::QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(zbcw_pkg::QUEUE_DEPTH + 1);

   zbcw_pkg::cmd_type slot_ff [zbcw_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;

   assign empty = (count_ff == CntW'(0));
   assign full  = (count_ff == CntW'(zbcw_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(zbcw_pkg::QUEUE_DEPTH - 1)) ?
                     PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(zbcw_pkg::QUEUE_DEPTH - 1)) ?
                     PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/zbcw_back.sv
// ----------------------------------------------------------------------------
// zbcw_back
// Cell engine: carries out queued commands against the cell memory, with
// the depth test as a read-modify-write and the clear as a full sweep.
// ----------------------------------------------------------------------------
module zbcw_back #(
   parameter int unsigned CELL_COUNT = zbcw_pkg::SCREEN_WIDTH_DEF *
                                       zbcw_pkg::SCREEN_HEIGHT_DEF,
   localparam int unsigned ADDR_W    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
   localparam int unsigned DATA_W    = zbcw_pkg::CHAR_W + zbcw_pkg::DEPTH_W
) (
   input  logic              clock,
   input  logic              reset,
   input  zbcw_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   output logic              init_busy,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [DATA_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [DATA_W-1:0] ram_rd_data,
   output logic              rsp_valid,
   output zbcw_pkg::rsp_type rsp_data
);

   zbcw_pkg::back_state_type state_ff;
   zbcw_pkg::back_state_type state_in;
   zbcw_pkg::cmd_type        item_ff;
   zbcw_pkg::cmd_type        item_in;
   logic [ADDR_W-1:0]        sweep_ff;
   logic [ADDR_W-1:0]        sweep_in;
   logic                     init_ff;
   logic                     init_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   zbcw_pkg::rsp_type        rsp_data_ff;
   zbcw_pkg::rsp_type        rsp_data_in;

   logic [zbcw_pkg::CHAR_W-1:0]         stored_char;
   logic signed [zbcw_pkg::DEPTH_W-1:0] stored_depth;
   logic                                sweep_last;

   assign stored_char  = ram_rd_data[DATA_W-1:zbcw_pkg::DEPTH_W];
   assign stored_depth = ram_rd_data[zbcw_pkg::DEPTH_W-1:0];
   assign sweep_last   = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = item_ff.cell_addr[ADDR_W-1:0];
      ram_wr_data  = {item_ff.char_code, item_ff.depth};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head.cell_addr[ADDR_W-1:0];
      unique case (state_ff)
         zbcw_pkg::BK_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               item_in = head;
               unique case (head.kind)
                  zbcw_pkg::CMD_WRITE, zbcw_pkg::CMD_READ: begin
                     if (head.in_bounds) begin
                        ram_rd_en = 1'b1;
                        state_in  = zbcw_pkg::BK_CHECK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  zbcw_pkg::CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = zbcw_pkg::BK_CLEAR;
                  end
                  zbcw_pkg::CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         zbcw_pkg::BK_CHECK: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.in_bounds = 1'b1;
            state_in              = zbcw_pkg::BK_IDLE;
            if ((item_ff.kind == zbcw_pkg::CMD_WRITE) &&
                ($signed(stored_depth) <= $signed(item_ff.depth))) begin
               ram_wr_en             = 1'b1;
               rsp_data_in.char_code = item_ff.char_code;
               rsp_data_in.depth_out = item_ff.depth;
               rsp_data_in.drawn     = 1'b1;
            end else begin
               rsp_data_in.char_code = stored_char;
               rsp_data_in.depth_out = stored_depth;
            end
         end
         zbcw_pkg::BK_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = {zbcw_pkg::SPACE_CODE, zbcw_pkg::DEPTH_W'(0)};
            sweep_in    = sweep_ff + ADDR_W'(1);
            if (sweep_last) begin
               state_in = zbcw_pkg::BK_IDLE;
               init_in  = 1'b0;
               if (!init_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.char_code = zbcw_pkg::SPACE_CODE;
               end
            end
         end
         default: begin
            state_in = zbcw_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zbcw_pkg::BK_CLEAR;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/zbuffer_char_cell_writer.sv
// ----------------------------------------------------------------------------
// zbuffer_char_cell_writer
// Character cell frame buffer with a per-cell depth test and brightness ramp.
// ----------------------------------------------------------------------------
// Requests are taken whenever busy is low and wait in a two-entry queue in
// front of the cell engine; every request gives exactly one response, which
// appears on rsp_data for a single cycle with rsp_valid high and must be
// captured then, as it cannot be held off. The cell engine works through one
// request at a time: a read or write of a cell on screen does a memory read,
// then the depth test and write-back; any other request except a clear is
// answered straight from idle; a clear sweeps every cell, writing one cell of
// the cell memory per cycle. After reset the same sweep of all SCREEN_WIDTH *
// SCREEN_HEIGHT cells (81920 at the default size) initialises the memory, and
// busy stays high until it is done.
// ----------------------------------------------------------------------------
module zbuffer_char_cell_writer #(
   parameter int unsigned SCREEN_WIDTH  = zbcw_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT = zbcw_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned RAMP_LEN      = zbcw_pkg::RAMP_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  zbcw_pkg::req_type req_data,
   output logic              rsp_valid,
   output zbcw_pkg::rsp_type rsp_data
);

   localparam int unsigned CellCount = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int unsigned AddrW     = (CellCount > 1) ? $clog2(CellCount) : 1;
   localparam int unsigned DataW     = zbcw_pkg::CHAR_W + zbcw_pkg::DEPTH_W;

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   logic              init_busy;
   zbcw_pkg::cmd_type push_entry;
   zbcw_pkg::cmd_type head;
   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [DataW-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [AddrW-1:0]  ram_rd_addr;
   logic [DataW-1:0]  ram_rd_data;

   zbcw_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .RAMP_LEN      (RAMP_LEN)
   ) u_front (
      .start      (start),
      .req        (req_data),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .busy       (busy),
      .push       (push),
      .entry      (push_entry)
   );

   zbcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   zbcw_back #(
      .CELL_COUNT (CellCount)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (queue_empty),
      .pop         (pop),
      .init_busy   (init_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   zbcw_ram #(
      .DATA_WIDTH (DataW),
      .DEPTH      (CellCount)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
